// ===== hdl/pcsl_pkg.sv =====
`default_nettype none
package pcsl_pkg;

  // Channel count limit; counts written above it saturate here.
  localparam logic [2:0] MAX_CHANNELS = 3'd4;

  // Q16 luminance weights.
  localparam logic [15:0] LUMA_AVG_W = 16'd21845;
  localparam logic [15:0] LUMA_WR    = 16'd13933;
  localparam logic [15:0] LUMA_WG    = 16'd46871;
  localparam logic [15:0] LUMA_WB    = 16'd4732;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SEL0    = 3'd0;
  localparam logic [2:0] CFG_SEL1    = 3'd1;
  localparam logic [2:0] CFG_SEL2    = 3'd2;
  localparam logic [2:0] CFG_SEL3    = 3'd3;
  localparam logic [2:0] CFG_OUT_CNT = 3'd4;
  localparam logic [2:0] CFG_IN_CNT  = 3'd5;
  localparam logic [2:0] CFG_DEPTH   = 3'd6;

  // Output channel source selector.
  typedef enum logic [2:0] {
    SEL_RED   = 3'd0,
    SEL_GREEN = 3'd1,
    SEL_BLUE  = 3'd2,
    SEL_ALPHA = 3'd3,
    SEL_ZERO  = 3'd4,
    SEL_ONE   = 3'd5,
    SEL_ALUMA = 3'd6,
    SEL_WLUMA = 3'd7
  } sel_t;

  // Sample depth mode; the unused code behaves as thirty-two bits.
  typedef enum logic [1:0] {
    DEPTH_8  = 2'd0,
    DEPTH_16 = 2'd1,
    DEPTH_32 = 2'd2
  } depth_t;

  // Configuration as seen by the pipeline, counts already saturated.
  typedef struct packed {
    sel_t [3:0] sel;
    logic [2:0] nout;
    logic [2:0] nin;
  } cfg_t;

  // Control that travels with each word down the pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

endpackage
`default_nettype wire

// ===== hdl/pcsl_mask.sv =====
`default_nettype none
module pcsl_mask #(
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire pcsl_pkg::cfg_t                  cfg,
  input  wire logic [SAMPLE_BITS-1:0]          mask,
  input  wire pcsl_pkg::ctl_t                  in_ctl,
  input  wire logic [3:0][31:0]                in_px,
  output      pcsl_pkg::ctl_t                  px_ctl,
  output      logic [3:0][SAMPLE_BITS-1:0]     px
);
  import pcsl_pkg::*;

  ctl_t                        ctl_r;
  logic [3:0][SAMPLE_BITS-1:0] px_r;
  logic [3:0][SAMPLE_BITS-1:0] px_nxt;

  // Trim each sample to the depth and zero the channels the input lacks.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < cfg.nin) begin
        px_nxt[k] = in_px[k][SAMPLE_BITS-1:0] & mask;
      end else begin
        px_nxt[k] = '0;
      end
    end
  end

  // Stage one control register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= in_ctl;
    end
  end

  // Stage one samples.
  always_ff @(posedge clk) begin
    if (in_ctl.valid) begin
      px_r <= px_nxt;
    end
  end

  assign px_ctl = ctl_r;
  assign px     = px_r;

endmodule
`default_nettype wire

// ===== hdl/pcsl_luma.sv =====
`default_nettype none
module pcsl_luma #(
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire pcsl_pkg::ctl_t                  px_ctl,
  input  wire logic [3:0][SAMPLE_BITS-1:0]     px,
  output      pcsl_pkg::ctl_t                  lu_ctl,
  output      logic [3:0][SAMPLE_BITS-1:0]     lu_px,
  output      logic [SAMPLE_BITS-1:0]          avg,
  output      logic [SAMPLE_BITS-1:0]          wl
);
  import pcsl_pkg::*;

  localparam int SW = SAMPLE_BITS + 2;   // sum of three samples
  localparam int MW = SAMPLE_BITS + 16;  // sample times Q16 weight
  localparam int PW = SAMPLE_BITS + 18;  // widest product or sum

  // Stage two: channel sum and the three weighted products.
  ctl_t                        s2_ctl_r;
  logic [3:0][SAMPLE_BITS-1:0] s2_px_r;
  logic [SW-1:0]               sum_r;
  logic [SW-1:0]               sum_nxt;
  logic [MW-1:0]               pr_r;
  logic [MW-1:0]               pg_r;
  logic [MW-1:0]               pb_r;
  logic [MW-1:0]               pr_nxt;
  logic [MW-1:0]               pg_nxt;
  logic [MW-1:0]               pb_nxt;

  // Stage three: scaled average and weighted sum.
  ctl_t                        s3_ctl_r;
  logic [3:0][SAMPLE_BITS-1:0] s3_px_r;
  logic [SAMPLE_BITS-1:0]      avg_r;
  logic [SAMPLE_BITS-1:0]      wl_r;
  logic [PW-1:0]               pavg;
  logic [PW-1:0]               wsum;

  assign sum_nxt = SW'(px[0]) + SW'(px[1]) + SW'(px[2]);
  assign pr_nxt  = MW'(px[0]) * MW'(LUMA_WR);
  assign pg_nxt  = MW'(px[1]) * MW'(LUMA_WG);
  assign pb_nxt  = MW'(px[2]) * MW'(LUMA_WB);

  assign pavg = PW'(sum_r) * PW'(LUMA_AVG_W);
  assign wsum = PW'(pr_r) + PW'(pg_r) + PW'(pb_r);

  // Control registers of stages two and three.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
    end else begin
      s2_ctl_r <= px_ctl;
      s3_ctl_r <= s2_ctl_r;
    end
  end

  // Stage two data.
  always_ff @(posedge clk) begin
    if (px_ctl.valid) begin
      s2_px_r <= px;
      sum_r   <= sum_nxt;
      pr_r    <= pr_nxt;
      pg_r    <= pg_nxt;
      pb_r    <= pb_nxt;
    end
  end

  // Stage three data; drop the Q16 fraction.
  always_ff @(posedge clk) begin
    if (s2_ctl_r.valid) begin
      s3_px_r <= s2_px_r;
      avg_r   <= pavg[SAMPLE_BITS+15:16];
      wl_r    <= wsum[SAMPLE_BITS+15:16];
    end
  end

  assign lu_ctl = s3_ctl_r;
  assign lu_px  = s3_px_r;
  assign avg    = avg_r;
  assign wl     = wl_r;

endmodule
`default_nettype wire

// ===== hdl/pcsl_mux.sv =====
`default_nettype none
module pcsl_mux #(
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire pcsl_pkg::cfg_t                  cfg,
  input  wire logic [SAMPLE_BITS-1:0]          mask,
  input  wire pcsl_pkg::ctl_t                  lu_ctl,
  input  wire logic [3:0][SAMPLE_BITS-1:0]     lu_px,
  input  wire logic [SAMPLE_BITS-1:0]          avg,
  input  wire logic [SAMPLE_BITS-1:0]          wl,
  output      pcsl_pkg::ctl_t                  out_ctl,
  output      logic [3:0][31:0]                out_ch
);
  import pcsl_pkg::*;

  ctl_t                        ctl_r;
  logic [3:0][31:0]            ch_r;
  logic [3:0][31:0]            ch_nxt;
  logic [3:0][SAMPLE_BITS-1:0] val;

  // Pick each output channel's source, then trim and blank unused channels.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      case (cfg.sel[k])
        SEL_RED:   val[k] = lu_px[0];
        SEL_GREEN: val[k] = lu_px[1];
        SEL_BLUE:  val[k] = lu_px[2];
        SEL_ALPHA: val[k] = lu_px[3];
        SEL_ZERO:  val[k] = '0;
        SEL_ONE:   val[k] = mask;
        SEL_ALUMA: val[k] = avg;
        SEL_WLUMA: val[k] = wl;
        default:   val[k] = '0;
      endcase
      if (3'(k) < cfg.nout) begin
        ch_nxt[k] = 32'(val[k] & mask);
      end else begin
        ch_nxt[k] = '0;
      end
    end
  end

  // Output stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= lu_ctl;
    end
  end

  // Output stage data.
  always_ff @(posedge clk) begin
    if (lu_ctl.valid) begin
      ch_r <= ch_nxt;
    end
  end

  assign out_ctl = ctl_r;
  assign out_ch  = ch_r;

endmodule
`default_nettype wire

// ===== hdl/pixel_channel_swizzle_luma_top.sv =====
`default_nettype none
// Channel   Ports                                        Handshake
// input     start, busy, in_red..in_alpha, in_last       start & !busy
// result    out_valid, out_res_ch0..3, out_res_last      out_valid, one cycle
// config    cfg_valid, cfg_ready, cfg_index, cfg_data    cfg_valid & cfg_ready
//
// Four register stages: mask, luma products, luma sums, output select.
// A pixel word can be started every cycle; its result word passes through the input
// register, the two multiply stages and the output register.
// busy is always low and cfg_ready always high.
// Synchronous active-low reset loads the default configuration and clears all valid bits.
// The receiver cannot stall; each result word is held for one cycle only.
module pixel_channel_swizzle_luma_top #(
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [31:0] in_red,
  input  wire logic [31:0] in_green,
  input  wire logic [31:0] in_blue,
  input  wire logic [31:0] in_alpha,
  input  wire logic        in_last,
  output      logic        out_valid,
  output      logic [31:0] out_res_ch0,
  output      logic [31:0] out_res_ch1,
  output      logic [31:0] out_res_ch2,
  output      logic [31:0] out_res_ch3,
  output      logic        out_res_last,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import pcsl_pkg::*;

  localparam int W16 = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
  localparam logic [SAMPLE_BITS-1:0] MASK8  = {SAMPLE_BITS{1'b1}} >> (SAMPLE_BITS - 8);
  localparam logic [SAMPLE_BITS-1:0] MASK16 = {SAMPLE_BITS{1'b1}} >> (SAMPLE_BITS - W16);
  localparam logic [SAMPLE_BITS-1:0] MASKF  = {SAMPLE_BITS{1'b1}};

  sel_t [3:0]             sel_r;
  logic [2:0]             out_cnt_r;
  logic [2:0]             in_cnt_r;
  depth_t                 depth_r;
  cfg_t                   cfg;
  logic [SAMPLE_BITS-1:0] mask;

  ctl_t                        in_ctl;
  ctl_t                        px_ctl;
  ctl_t                        lu_ctl;
  ctl_t                        out_ctl;
  logic [3:0][31:0]            in_px;
  logic [3:0][SAMPLE_BITS-1:0] px;
  logic [3:0][SAMPLE_BITS-1:0] lu_px;
  logic [SAMPLE_BITS-1:0]      avg;
  logic [SAMPLE_BITS-1:0]      wl;
  logic [3:0][31:0]            out_ch;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r[0]  <= SEL_RED;
      sel_r[1]  <= SEL_GREEN;
      sel_r[2]  <= SEL_BLUE;
      sel_r[3]  <= SEL_ALPHA;
      out_cnt_r <= 3'd4;
      in_cnt_r  <= 3'd4;
      depth_r   <= DEPTH_8;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SEL0:    sel_r[0]  <= sel_t'(cfg_data[2:0]);
        CFG_SEL1:    sel_r[1]  <= sel_t'(cfg_data[2:0]);
        CFG_SEL2:    sel_r[2]  <= sel_t'(cfg_data[2:0]);
        CFG_SEL3:    sel_r[3]  <= sel_t'(cfg_data[2:0]);
        CFG_OUT_CNT: out_cnt_r <= cfg_data[2:0];
        CFG_IN_CNT:  in_cnt_r  <= cfg_data[2:0];
        CFG_DEPTH:   depth_r   <= depth_t'(cfg_data[1:0]);
        default:     ;
      endcase
    end
  end

  // Saturated counts and the sample mask for the current depth.
  always_comb begin
    cfg.sel  = sel_r;
    cfg.nout = (out_cnt_r > MAX_CHANNELS) ? MAX_CHANNELS : out_cnt_r;
    cfg.nin  = (in_cnt_r > MAX_CHANNELS) ? MAX_CHANNELS : in_cnt_r;
    case (depth_r)
      DEPTH_8:  mask = MASK8;
      DEPTH_16: mask = MASK16;
      DEPTH_32: mask = MASKF;
      default:  mask = MASKF;
    endcase
  end

  assign in_ctl.valid = start && !busy;
  assign in_ctl.last  = in_last;
  assign in_px[0]     = in_red;
  assign in_px[1]     = in_green;
  assign in_px[2]     = in_blue;
  assign in_px[3]     = in_alpha;

  pcsl_mask #(.SAMPLE_BITS(SAMPLE_BITS)) u_mask (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .mask   (mask),
    .in_ctl (in_ctl),
    .in_px  (in_px),
    .px_ctl (px_ctl),
    .px     (px)
  );

  pcsl_luma #(.SAMPLE_BITS(SAMPLE_BITS)) u_luma (
    .clk    (clk),
    .rst_n  (rst_n),
    .px_ctl (px_ctl),
    .px     (px),
    .lu_ctl (lu_ctl),
    .lu_px  (lu_px),
    .avg    (avg),
    .wl     (wl)
  );

  pcsl_mux #(.SAMPLE_BITS(SAMPLE_BITS)) u_mux (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .mask    (mask),
    .lu_ctl  (lu_ctl),
    .lu_px   (lu_px),
    .avg     (avg),
    .wl      (wl),
    .out_ctl (out_ctl),
    .out_ch  (out_ch)
  );

  assign out_valid    = out_ctl.valid;
  assign out_res_last = out_ctl.last;
  assign out_res_ch0  = out_ch[0];
  assign out_res_ch1  = out_ch[1];
  assign out_res_ch2  = out_ch[2];
  assign out_res_ch3  = out_ch[3];

endmodule
`default_nettype wire
